// ===== sv/spcg_pkg.sv =====
// types, constants and tables shared by the swirl pixel color generator
`default_nettype none

package spcg_pkg;

   localparam int COORD_W     = 9;
   localparam int COLOR_W     = 16;
   localparam int SLOT_W      = 4;
   localparam int PHASE_W     = 5;
   localparam int ANGLE_W     = 8;
   localparam int SUM_W       = 10;
   localparam int RAD_RAW_W   = 10;
   localparam int TAN_STEPS   = 30;
   localparam int PAL_SIZE    = 8;

   localparam int unsigned PHASE_STEPS  = 240;
   localparam int unsigned SLOT_STEP    = 30;
   localparam int unsigned FRAME_MOD    = 22;
   localparam int unsigned START_PHASE  = 35;
   localparam int unsigned OCTANT_QUAD  = 60;
   localparam int unsigned HALF_TURN    = 120;
   localparam int unsigned RAD_BIG_K    = 1007;
   localparam int unsigned RAD_SMALL_K  = 441;
   localparam int unsigned RAD_ROUND    = 512;
   localparam int unsigned RAD_SHIFT    = 10;
   localparam int unsigned CORE_NUM     = 24;
   localparam int unsigned CORE_BIAS    = 200;
   localparam int unsigned CORE_DEN     = 400;
   localparam longint unsigned TWIST_Q16 = 64'd1591843;

   localparam logic [COORD_W-1:0] WIDTH_RESET  = 9'd135;
   localparam logic [COLOR_W-1:0] CORE_RGB     = 16'h2124;
   localparam logic [SLOT_W-1:0]  CORE_SLOT    = 4'd8;

   typedef logic [7:0] thresh_type [TAN_STEPS];

   // ceil(255*tan(k*1.5 deg)) for k = 1..30
   localparam thresh_type TAN_THRESH = '{
      8'd7,   8'd14,  8'd21,  8'd27,  8'd34,  8'd41,  8'd48,  8'd55,  8'd62,  8'd69,
      8'd76,  8'd83,  8'd91,  8'd98,  8'd106, 8'd114, 8'd122, 8'd130, 8'd139, 8'd148,
      8'd157, 8'd166, 8'd176, 8'd186, 8'd196, 8'd207, 8'd218, 8'd230, 8'd242, 8'd255};

   typedef logic [COLOR_W-1:0] palette_type [PAL_SIZE];

   localparam palette_type PALETTE = '{
      16'h8628, 16'h0512, 16'h13B7, 16'h6171,
      16'hC110, 16'hE90B, 16'hEAC6, 16'hF5A5};

   // animation offset: frame*240/22
   function automatic logic [ANGLE_W-1:0] frame_offset(input logic [PHASE_W-1:0] frame);
      logic [ANGLE_W-1:0] result;
      case (frame)
         5'd0:    result = 8'd0;
         5'd1:    result = 8'd10;
         5'd2:    result = 8'd21;
         5'd3:    result = 8'd32;
         5'd4:    result = 8'd43;
         5'd5:    result = 8'd54;
         5'd6:    result = 8'd65;
         5'd7:    result = 8'd76;
         5'd8:    result = 8'd87;
         5'd9:    result = 8'd98;
         5'd10:   result = 8'd109;
         5'd11:   result = 8'd120;
         5'd12:   result = 8'd130;
         5'd13:   result = 8'd141;
         5'd14:   result = 8'd152;
         5'd15:   result = 8'd163;
         5'd16:   result = 8'd174;
         5'd17:   result = 8'd185;
         5'd18:   result = 8'd196;
         5'd19:   result = 8'd207;
         5'd20:   result = 8'd218;
         5'd21:   result = 8'd229;
         default: result = 8'd0;
      endcase
      return result;
   endfunction

endpackage

`default_nettype wire

// ===== sv/swirl_pixel_color_generator.sv =====
// Swirl pixel color generator: six-stage pipeline from pixel coordinate to RGB565 color.
// Throughput one pixel per clock while the output is not stalled.
// Each stage holds its own valid bit and fills when empty or when the next stage moves,
// so bubbles collapse under output stall and nothing is dropped or repeated.
// Reset (synchronous, active high) clears all valid bits, the frame counter to 0 and
// the screen width to 135.
`default_nettype none

module swirl_pixel_color_generator #(
   parameter int DISPLAY_HEIGHT = 240,
   parameter int MAX_RADIUS     = 160
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            csr_write_enable,
   input  wire  [spcg_pkg::COORD_W-1:0]   csr_write_data,
   input  wire                            req_valid,
   output logic                           req_ready,
   input  wire  [spcg_pkg::COORD_W-1:0]   req_pixel_x,
   input  wire  [spcg_pkg::COORD_W-1:0]   req_pixel_y,
   input  wire                            req_frame_end,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output logic [spcg_pkg::COLOR_W-1:0]   rsp_pixel_color,
   output logic [spcg_pkg::SLOT_W-1:0]    rsp_palette_slot
);
   import spcg_pkg::*;

   localparam int RADIUS_W = $clog2(MAX_RADIUS + 1);
   localparam int CORE_RAW = (DISPLAY_HEIGHT * CORE_NUM + CORE_BIAS) / CORE_DEN;
   localparam int CORE     = (CORE_RAW == 0) ? 1 : CORE_RAW;
   localparam int CENTER_Y = DISPLAY_HEIGHT / 2;
   localparam longint unsigned TWIST_FULL = longint'(PHASE_STEPS) << 16;

   typedef struct packed {
      logic [COORD_W-1:0] ax;
      logic [COORD_W-1:0] ay;
      logic               neg_x;
      logic               neg_y;
      logic [ANGLE_W-1:0] offset;
   } s1_type;

   typedef struct packed {
      logic [COORD_W-1:0] big;
      logic [COORD_W-1:0] small_side;
      logic               steep;
      logic               neg_x;
      logic               neg_y;
      logic [ANGLE_W-1:0] offset;
      logic [18:0]        prod_big;
      logic [17:0]        prod_small;
   } s2_type;

   typedef struct packed {
      logic [TAN_STEPS-1:0] above;
      logic [RADIUS_W-1:0]  radius;
      logic                 core;
      logic                 steep;
      logic                 neg_x;
      logic                 neg_y;
      logic [ANGLE_W-1:0]   offset;
   } s3_type;

   typedef struct packed {
      logic [4:0]         octant;
      logic [ANGLE_W-1:0] twist;
      logic               core;
      logic               steep;
      logic               neg_x;
      logic               neg_y;
      logic [ANGLE_W-1:0] offset;
   } s4_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic             core;
   } s5_type;

   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic [SLOT_W-1:0]  slot;
   } s6_type;

   // twist per clamped radius, built at elaboration
   logic [ANGLE_W-1:0] twist_rom [0:MAX_RADIUS];

   for (genvar r = 0; r <= MAX_RADIUS; r++) begin : g_twist
      localparam longint unsigned S    = (r > CORE) ? r : CORE;
      localparam longint unsigned V    = (longint'(DISPLAY_HEIGHT) * TWIST_Q16) / S;
      localparam longint unsigned M    = V % TWIST_FULL;
      localparam longint unsigned UNIT = (M == 0) ? 0 : ((TWIST_FULL - M) >> 16);
      assign twist_rom[r] = ANGLE_W'(UNIT);
   end

   logic [COORD_W-1:0] screen_width_ff;
   logic [PHASE_W-1:0] frame_phase_ff, frame_phase_in;

   logic   v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic   en1, en2, en3, en4, en5, en6;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;
   s6_type s6_ff, s6_in;

   // a stage loads when it is empty or its content moves on
   assign en6 = !v6_ff || rsp_ready;
   assign en5 = !v5_ff || en6;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_ready = en1;

   assign rsp_valid        = v6_ff;
   assign rsp_pixel_color  = s6_ff.color;
   assign rsp_palette_slot = s6_ff.slot;

   assign frame_phase_in = (frame_phase_ff == PHASE_W'(FRAME_MOD - 1)) ? '0
                                                                      : frame_phase_ff + 1'b1;

   // stage 1: offset from center and magnitudes
   always_comb begin
      logic signed [COORD_W:0] dx;
      logic signed [COORD_W:0] dy;
      dx = $signed({1'b0, req_pixel_x}) - $signed({2'b00, screen_width_ff[COORD_W-1:1]});
      dy = $signed({1'b0, req_pixel_y}) - $signed(10'(CENTER_Y));
      s1_in.neg_x  = dx[COORD_W];
      s1_in.neg_y  = dy[COORD_W];
      s1_in.ax     = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
      s1_in.ay     = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
      s1_in.offset = frame_offset(frame_phase_ff);
   end

   // stage 2: sort sides and weight them for the radius estimate
   always_comb begin
      logic steep;
      steep = s1_ff.ay > s1_ff.ax;
      s2_in.steep      = steep;
      s2_in.big        = steep ? s1_ff.ay : s1_ff.ax;
      s2_in.small_side = steep ? s1_ff.ax : s1_ff.ay;
      s2_in.neg_x      = s1_ff.neg_x;
      s2_in.neg_y      = s1_ff.neg_y;
      s2_in.offset     = s1_ff.offset;
      s2_in.prod_big   = 19'(RAD_BIG_K) * 19'(steep ? s1_ff.ay : s1_ff.ax);
      s2_in.prod_small = 18'(RAD_SMALL_K) * 18'(steep ? s1_ff.ax : s1_ff.ay);
   end

   // stage 3: radius, core test, clamp and tangent threshold compares
   always_comb begin
      logic [19:0]          rsum;
      logic [RAD_RAW_W-1:0] radius_raw;
      logic [16:0]          lhs;
      rsum       = 20'(s2_ff.prod_big) + 20'(s2_ff.prod_small) + 20'(RAD_ROUND);
      radius_raw = rsum[RAD_SHIFT +: RAD_RAW_W];
      s3_in.core   = radius_raw <= RAD_RAW_W'(CORE);
      s3_in.radius = (radius_raw > RAD_RAW_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS)
                                                           : radius_raw[RADIUS_W-1:0];
      // floor(small*255/big) >= T  iff  small*255 >= T*big
      lhs = {s2_ff.small_side, 8'd0} - 17'(s2_ff.small_side);
      for (int k = 0; k < TAN_STEPS; k++) begin
         s3_in.above[k] = lhs >= (17'(TAN_THRESH[k]) * 17'(s2_ff.big));
      end
      s3_in.steep  = s2_ff.steep;
      s3_in.neg_x  = s2_ff.neg_x;
      s3_in.neg_y  = s2_ff.neg_y;
      s3_in.offset = s2_ff.offset;
   end

   // stage 4: octant angle count and twist lookup
   always_comb begin
      s4_in.octant = 5'($countones(s3_ff.above));
      s4_in.twist  = twist_rom[s3_ff.radius];
      s4_in.core   = s3_ff.core;
      s4_in.steep  = s3_ff.steep;
      s4_in.neg_x  = s3_ff.neg_x;
      s4_in.neg_y  = s3_ff.neg_y;
      s4_in.offset = s3_ff.offset;
   end

   // stage 5: unfold octant to full turn, add twist and start, remove animation offset
   always_comb begin
      logic [ANGLE_W-1:0] angle;
      angle = ANGLE_W'(s4_ff.octant);
      if (s4_ff.steep) begin
         angle = ANGLE_W'(OCTANT_QUAD) - angle;
      end
      if (s4_ff.neg_x) begin
         angle = s4_ff.neg_y ? ANGLE_W'(HALF_TURN) + angle : ANGLE_W'(HALF_TURN) - angle;
      end else if (s4_ff.neg_y) begin
         angle = (angle == '0) ? '0 : ANGLE_W'(PHASE_STEPS) - angle;
      end
      s5_in.sum  = SUM_W'(angle) + SUM_W'(s4_ff.twist) + SUM_W'(START_PHASE)
                 + SUM_W'(PHASE_STEPS) - SUM_W'(s4_ff.offset);
      s5_in.core = s4_ff.core;
   end

   // stage 6: wrap phase, pick palette slot
   always_comb begin
      logic [SUM_W-1:0]  phase;
      logic [SLOT_W-1:0] slot;
      if (s5_ff.sum >= SUM_W'(3 * PHASE_STEPS)) begin
         phase = s5_ff.sum - SUM_W'(3 * PHASE_STEPS);
      end else if (s5_ff.sum >= SUM_W'(2 * PHASE_STEPS)) begin
         phase = s5_ff.sum - SUM_W'(2 * PHASE_STEPS);
      end else if (s5_ff.sum >= SUM_W'(PHASE_STEPS)) begin
         phase = s5_ff.sum - SUM_W'(PHASE_STEPS);
      end else begin
         phase = s5_ff.sum;
      end
      slot = '0;
      for (int j = 1; j < PAL_SIZE; j++) begin
         if (phase >= SUM_W'(j * SLOT_STEP)) begin
            slot = SLOT_W'(j);
         end
      end
      if (s5_ff.core) begin
         s6_in.color = CORE_RGB;
         s6_in.slot  = CORE_SLOT;
      end else begin
         s6_in.color = PALETTE[slot[2:0]];
         s6_in.slot  = slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff <= WIDTH_RESET;
         frame_phase_ff  <= '0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            screen_width_ff <= csr_write_data;
         end
         // the last pixel still uses the old frame count
         if (req_valid && req_ready && req_frame_end) begin
            frame_phase_ff <= frame_phase_in;
         end
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) s1_ff <= s1_in;
      if (en2) s2_ff <= s2_in;
      if (en3) s3_ff <= s3_in;
      if (en4) s4_ff <= s4_in;
      if (en5) s5_ff <= s5_in;
      if (en6) s6_ff <= s6_in;
   end

endmodule

`default_nettype wire

// ===== tb/sv/swirl_pixel_color_generator_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the swirl pixel color generator
module swirl_pixel_color_generator_tb;

   localparam int XW          = spcg_pkg::COORD_W;
   localparam int CW          = spcg_pkg::COLOR_W;
   localparam int SW          = spcg_pkg::SLOT_W;
   localparam int DISP_H      = 240;
   localparam int RAD_CAP     = 160;
   localparam int TURN        = 240;
   localparam int FRAME_WRAP  = 22;
   localparam int SWIRL_START = 35;
   localparam int CORE_R      = ((DISP_H * 24 + 200) / 400 == 0) ? 1 : (DISP_H * 24 + 200) / 400;
   localparam longint unsigned TWIST_K = 64'd1591843;
   localparam int PIPE_DRAIN   = 12;
   localparam int LONG_HOLD    = 80;
   localparam int PHASE_PIXELS = 185;
   localparam int PHASE_COUNT  = 8;
   localparam int CYCLE_LIMIT  = 200000;

   // first index is the smallest angle step
   localparam logic [0:29][7:0] TAN_EDGE = {
      8'd7,   8'd14,  8'd21,  8'd27,  8'd34,  8'd41,  8'd48,  8'd55,  8'd62,  8'd69,
      8'd76,  8'd83,  8'd91,  8'd98,  8'd106, 8'd114, 8'd122, 8'd130, 8'd139, 8'd148,
      8'd157, 8'd166, 8'd176, 8'd186, 8'd196, 8'd207, 8'd218, 8'd230, 8'd242, 8'd255};
   localparam logic [0:7][15:0] SWIRL_PAL = {
      16'h8628, 16'h0512, 16'h13B7, 16'h6171,
      16'hC110, 16'hE90B, 16'hEAC6, 16'hF5A5};
   localparam logic [CW-1:0] GRAY = 16'h2124;

   typedef enum logic [1:0] {PACE_FREE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_type;

   typedef struct packed {
      logic [XW-1:0] x;
      logic [XW-1:0] y;
      logic          last;
   } pixel_type;

   typedef struct packed {
      logic [CW-1:0] color;
      logic [SW-1:0] slot;
   } shade_type;

   logic          clock            = 1'b0;
   logic          reset            = 1'b1;
   logic          csr_write_enable = 1'b0;
   logic [XW-1:0] csr_write_data   = '0;
   logic          req_valid        = 1'b0;
   logic          req_ready;
   logic [XW-1:0] req_pixel_x      = '0;
   logic [XW-1:0] req_pixel_y      = '0;
   logic          req_frame_end    = 1'b0;
   logic          rsp_valid;
   logic          rsp_ready        = 1'b0;
   logic [CW-1:0] rsp_pixel_color;
   logic [SW-1:0] rsp_palette_slot;

   pixel_type     pending_pixels[$];
   shade_type     expected_shades[$];
   pixel_type     next_px;
   shade_type     want;
   logic [XW-1:0] width_now   = 9'd135;
   logic [4:0]    frame_count = '0;
   int            gap_pct     = 0;
   int            stall_pct   = 0;
   logic          hold_arm    = 1'b0;
   logic          hold_done   = 1'b0;
   int            hold_left   = 0;
   int            errors      = 0;
   int            checked     = 0;
   int            frames_seen = 0;
   int            widths_used = 1;
   int            cycles      = 0;

   swirl_pixel_color_generator u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_x      (req_pixel_x),
      .req_pixel_y      (req_pixel_y),
      .req_frame_end    (req_frame_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_color  (rsp_pixel_color),
      .rsp_palette_slot (rsp_palette_slot)
   );

   always #5 clock = ~clock;

   function automatic shade_type predict_shade(input pixel_type p, input logic [XW-1:0] width,
                                               input logic [4:0] fc);
      int dx, dy, ax, ay, big, lil, radius, ratio, angle, twist, offset, phase, k;
      longint unsigned v, m, full;
      shade_type s;
      dx = int'(p.x) - int'(width / 2);
      dy = int'(p.y) - DISP_H / 2;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      big = ax > ay ? ax : ay;
      lil = ax > ay ? ay : ax;
      radius = (1007 * big + 441 * lil + 512) >> 10;
      offset = (int'(fc) % FRAME_WRAP) * TURN / FRAME_WRAP;
      if (radius <= CORE_R) begin
         s.color = GRAY;
         s.slot  = spcg_pkg::CORE_SLOT;
      end else begin
         if (radius > RAD_CAP) radius = RAD_CAP;
         ratio = lil * 255 / big;
         angle = 0;
         for (k = 0; k < 30; k++)
            if (ratio >= int'(TAN_EDGE[k])) angle++;
         // fold the octant angle out to the full turn
         if (ay > ax) angle = 60 - angle;
         if (dx < 0) angle = dy < 0 ? 120 + angle : 120 - angle;
         else if (dy < 0) angle = (TURN - angle) % TURN;
         // twist is the negated q16 value, reduced mod one turn and floored
         full = 64'(TURN) << 16;
         v = 64'(DISP_H) * TWIST_K / 64'(radius);
         m = v % full;
         twist = (m == 0) ? 0 : int'((full - m) >> 16);
         phase = (angle + twist + SWIRL_START) % TURN;
         phase = (phase + TURN - offset) % TURN;
         s.slot  = SW'(phase / (TURN / 8));
         s.color = SWIRL_PAL[phase / (TURN / 8)];
      end
      return s;
   endfunction

   // sender: one pixel offered at a time, held until its transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_shades.push_back(predict_shade({req_pixel_x, req_pixel_y, req_frame_end},
                                                    width_now, frame_count));
            if (req_frame_end) begin
               frame_count <= 5'((int'(frame_count) + 1) % FRAME_WRAP);
               frames_seen++;
            end
         end
         if (!req_valid || req_ready) begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= gap_pct) begin
               next_px = pending_pixels.pop_front();
               req_valid     <= 1'b1;
               req_pixel_x   <= next_px.x;
               req_pixel_y   <= next_px.y;
               req_frame_end <= next_px.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long output hold so the pipeline fills and backs up into the input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_arm && !hold_done) begin
         hold_left <= LONG_HOLD;
         hold_done <= 1'b1;
      end
   end

   // receiver: checks each transfer, then picks the next ready level
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_shades.size() == 0) begin
               $error("result with no pixel pending: pixel_color %h palette_slot %0d",
                      rsp_pixel_color, rsp_palette_slot);
               errors++;
            end else begin
               want = expected_shades.pop_front();
               if (rsp_pixel_color !== want.color) begin
                  $error("pixel_color expected %h actual %h", want.color, rsp_pixel_color);
                  errors++;
               end
               if (rsp_palette_slot !== want.slot) begin
                  $error("palette_slot expected %0d actual %0d", want.slot, rsp_palette_slot);
                  errors++;
               end
               checked++;
            end
         end
         if (hold_left != 0 || (hold_arm && !hold_done)) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("swirl_pixel_color_generator verification failed");
         $finish;
      end
   end

   task automatic push_px(input int x, input int y, input logic last);
      pending_pixels.push_back('{x: XW'(x), y: XW'(y), last: last});
   endtask

   task automatic load_directed();
      int cx, cy;
      cx = 135 / 2;
      cy = DISP_H / 2;
      push_px(cx, cy, 1'b0);                  // center, radius zero
      push_px(cx + 10, cy, 1'b0);
      push_px(cx + 14, cy, 1'b0);             // last radius inside the core
      push_px(cx + 15, cy, 1'b0);             // first radius outside it
      push_px(0, 0, 1'b0);
      push_px(511, 511, 1'b0);                // far off screen, radius clamped
      push_px(0, 511, 1'b0);
      push_px(511, 0, 1'b0);
      push_px(cx, 0, 1'b0);                   // on the axes
      push_px(cx, 300, 1'b0);
      push_px(0, cy, 1'b0);
      push_px(300, cy, 1'b0);
      push_px(cx + 50, cy + 50, 1'b0);        // diagonals, ratio at full scale
      push_px(cx - 50, cy - 50, 1'b0);
      push_px(cx - 50, cy + 50, 1'b0);
      push_px(cx + 50, cy - 50, 1'b0);
      push_px(cx + 40, cy + 7, 1'b1);         // frame ends, still old counter
      push_px(cx + 40, cy + 7, 1'b1);
      push_px(cx + 40, cy + 7, 1'b0);
      push_px(511, 511, 1'b1);
      push_px(cx - 3, cy + 90, 1'b0);
   endtask

   task automatic load_random(input int n);
      int added, kind, x0, y0, cols, rows, r, c;
      added = 0;
      while (added < n) begin
         kind = $urandom_range(9);
         if (kind < 6) begin
            // short raster run, usually closing a frame
            x0   = $urandom_range(511);
            y0   = $urandom_range(511);
            cols = $urandom_range(1, 12);
            rows = $urandom_range(1, 4);
            for (r = 0; r < rows; r++)
               for (c = 0; c < cols; c++) begin
                  push_px(x0 + c, y0 + r,
                          (r == rows - 1) && (c == cols - 1) && ($urandom_range(3) != 0));
                  added++;
               end
         end else if (kind < 8) begin
            // near the center, where the core edge and the tightest twist sit
            push_px(int'(width_now / 2) + int'($urandom_range(40)) - 20,
                    DISP_H / 2 + int'($urandom_range(40)) - 20, $urandom_range(19) == 0);
            added++;
         end else begin
            push_px($urandom_range(511), $urandom_range(511), $urandom_range(15) == 0);
            added++;
         end
      end
   endtask

   task automatic set_width(input logic [XW-1:0] w);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= w;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      width_now        <= w;
      widths_used++;
      @(posedge clock);
   endtask

   task automatic drain();
      while (pending_pixels.size() != 0 || req_valid || expected_shades.size() != 0)
         @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   initial begin
      pace_type pace;
      int ph;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph)
            0:       ;
            1:       set_width(9'd240);
            2:       set_width(9'd0);
            3:       set_width(9'd511);
            4:       set_width(9'd1);
            default: set_width(XW'($urandom_range(511)));
         endcase
         pace = pace_type'(ph % 4);
         case (pace)
            PACE_FREE:     begin gap_pct <= 0;  stall_pct <= 0;  end
            PACE_SENDER:   begin gap_pct <= 48; stall_pct <= 0;  end
            PACE_RECEIVER: begin gap_pct <= 0;  stall_pct <= 48; end
            PACE_BOTH:     begin gap_pct <= 31; stall_pct <= 31; end
         endcase
         if (ph == 0) begin
            load_directed();
            hold_arm <= 1'b1;
         end
         load_random(PHASE_PIXELS);
         drain();
      end
      $display("checked %0d pixels over %0d screen widths, frame counter advanced %0d times",
               checked, widths_used, frames_seen);
      $display("pacing: free run, sender gaps, receiver stalls, both, one %0d-cycle output hold",
               LONG_HOLD);
      if (errors == 0 && expected_shades.size() == 0)
         $display("swirl_pixel_color_generator verification clean");
      else
         $display("swirl_pixel_color_generator verification failed");
      $finish;
   end

endmodule
